[hw/rtl/mll_pkg.sv]
// Shared types, codes and keyword tables for the micro language lexer.
// No dependencies; the core, result queue, top level and checker import this package.
`timescale 1ns / 1ps

package mll_pkg;

  // Line counter width and the width of the reported line number.
  localparam int LINE_WIDTH = 16;
  localparam int LINE_NO_W  = 16;
  localparam int LINE_EXT_W = (LINE_WIDTH > LINE_NO_W) ? LINE_WIDTH : LINE_NO_W;

  // Identifier length counter saturates at its all-ones value.
  localparam int ID_LEN_W = 3;
  localparam int KW_COUNT = 4;

  // Result queue, a power of two deep.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result kinds.
  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Token codes.
  localparam logic [3:0] TOK_BEGIN     = 4'd0;
  localparam logic [3:0] TOK_END       = 4'd1;
  localparam logic [3:0] TOK_READ      = 4'd2;
  localparam logic [3:0] TOK_WRITE     = 4'd3;
  localparam logic [3:0] TOK_IDENT     = 4'd4;
  localparam logic [3:0] TOK_INT_LIT   = 4'd5;
  localparam logic [3:0] TOK_REAL_LIT  = 4'd6;
  localparam logic [3:0] TOK_LPAREN    = 4'd7;
  localparam logic [3:0] TOK_RPAREN    = 4'd8;
  localparam logic [3:0] TOK_SEMICOLON = 4'd9;
  localparam logic [3:0] TOK_COMMA     = 4'd10;
  localparam logic [3:0] TOK_ASSIGN    = 4'd11;
  localparam logic [3:0] TOK_PLUS      = 4'd12;
  localparam logic [3:0] TOK_MINUS     = 4'd13;
  localparam logic [3:0] TOK_EOF       = 4'd14;
  localparam logic [3:0] TOK_NONE      = 4'd0;

  // One result item.
  typedef struct packed {
    logic [1:0]           kind;
    logic [3:0]           token_code;
    logic [LINE_NO_W-1:0] line_no;
    logic                 last;
  } result_t;

  // Results of one processed item handed from the core to the queue.
  typedef struct packed {
    logic    valid;
    logic    two;
    result_t first;
    result_t second;
  } push_t;

  // Length of each keyword.
  function automatic logic [ID_LEN_W-1:0] kw_len(input logic [1:0] k);
    logic [ID_LEN_W-1:0] len;
    unique case (k)
      2'd0:    len = ID_LEN_W'(5);
      2'd1:    len = ID_LEN_W'(3);
      2'd2:    len = ID_LEN_W'(4);
      default: len = ID_LEN_W'(5);
    endcase
    return len;
  endfunction

  // Character at a position of each keyword: begin, end, read, write.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [ID_LEN_W-1:0] idx);
    logic [7:0] c;
    unique case ({k, idx})
      {2'd0, 3'd0}: c = "b";
      {2'd0, 3'd1}: c = "e";
      {2'd0, 3'd2}: c = "g";
      {2'd0, 3'd3}: c = "i";
      {2'd0, 3'd4}: c = "n";
      {2'd1, 3'd0}: c = "e";
      {2'd1, 3'd1}: c = "n";
      {2'd1, 3'd2}: c = "d";
      {2'd2, 3'd0}: c = "r";
      {2'd2, 3'd1}: c = "e";
      {2'd2, 3'd2}: c = "a";
      {2'd2, 3'd3}: c = "d";
      {2'd3, 3'd0}: c = "w";
      {2'd3, 3'd1}: c = "r";
      {2'd3, 3'd2}: c = "i";
      {2'd3, 3'd3}: c = "t";
      {2'd3, 3'd4}: c = "e";
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/mll_in_if.sv]
// Input channel of the lexer: one source byte or an end-of-input mark per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface mll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

[hw/rtl/mll_out_if.sv]
// Output channel of the lexer: one token, line-end or error result per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface mll_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  token_code;
  logic [15:0] line_no;
  logic        last;

  modport source (output valid, output kind, output token_code, output line_no, output last,
                  input ready);
  modport sink (input valid, input kind, input token_code, input line_no, input last,
                output ready);
endinterface

[hw/rtl/mll_core.sv]
// Scanner core: input register, mode machine, keyword match and line counter.
// Depends on mll_pkg and mll_in_if; hands up to two results per item to the queue.
`timescale 1ns / 1ps

module mll_core
  import mll_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mll_in_if.sink      chars,
  input  logic        room,
  output push_t       push
);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_LEADDOT, M_FRAC, M_EXP_E,
    M_EXP_SIGN, M_EXP_DIG, M_COLON, M_MINUS, M_COMMENT
  } mode_t;

  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_UNDERSCORE = "_";
  localparam logic [7:0] CH_DOT        = ".";
  localparam logic [7:0] CH_LOWER_E    = "e";
  localparam logic [7:0] CH_UPPER_E    = "E";
  localparam logic [7:0] CH_EQUAL      = "=";
  localparam logic [7:0] CH_MINUS      = "-";
  localparam logic [7:0] CH_PLUS       = "+";
  localparam logic [7:0] CH_COLON      = ":";
  localparam logic [7:0] CH_LPAREN     = "(";
  localparam logic [7:0] CH_RPAREN     = ")";
  localparam logic [7:0] CH_SEMICOLON  = ";";
  localparam logic [7:0] CH_COMMA      = ",";

  // Input register.
  logic       held;
  logic [7:0] ch_q;
  logic       eoi_q;

  // Scanner state.
  mode_t                 mode, mode_next;
  logic [KW_COUNT-1:0]   kw, kw_next;
  logic [ID_LEN_W-1:0]   len, len_next;
  logic [LINE_WIDTH-1:0] line, line_next;

  logic take;

  logic       e0, e1, go_idle;
  logic [1:0] e0_kind, e1_kind;
  logic [3:0] e0_code, e1_code;
  logic [LINE_EXT_W-1:0] line_ext, line_next_ext;
  result_t r0, r1;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // Drop every keyword that the new character rules out.
  function automatic logic [KW_COUNT-1:0] kw_after(input logic [KW_COUNT-1:0] m,
                                                   input logic [ID_LEN_W-1:0] n,
                                                   input logic [7:0] c);
    logic [KW_COUNT-1:0] r;
    r = m;
    for (int k = 0; k < KW_COUNT; k++) begin
      if ((n >= kw_len(2'(k))) || (kw_char(2'(k), n) != c)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [ID_LEN_W-1:0] len_after(input logic [ID_LEN_W-1:0] n);
    return (n == '1) ? n : n + ID_LEN_W'(1);
  endfunction

  // Lowest-numbered keyword that matches in full, else an identifier.
  function automatic logic [3:0] ident_code(input logic [KW_COUNT-1:0] m,
                                            input logic [ID_LEN_W-1:0] n);
    logic [3:0] code;
    code = TOK_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (m[k] && (n == kw_len(2'(k)))) begin
        code = 4'(k);
      end
    end
    return code;
  endfunction

  function automatic logic [LINE_WIDTH-1:0] line_inc(input logic [LINE_WIDTH-1:0] v);
    return (v == '1) ? v : v + LINE_WIDTH'(1);
  endfunction

  // An item is taken from the input register once the queue has room for two results.
  assign take        = held && room;
  assign chars.ready = !held || room;

  // Next state and results of the held item.
  always_comb begin
    mode_next = mode;
    kw_next   = kw;
    len_next  = len;
    line_next = line;
    e0        = 1'b0;
    e0_kind   = KIND_TOKEN;
    e0_code   = TOK_NONE;
    e1        = 1'b0;
    e1_kind   = KIND_TOKEN;
    e1_code   = TOK_NONE;
    go_idle   = 1'b0;
    if (eoi_q) begin
      // End of input flushes the pending token, then reports eof.
      unique case (mode)
        M_IDENT: begin
          e0      = 1'b1;
          e0_code = ident_code(kw, len);
        end
        M_INT: begin
          e0      = 1'b1;
          e0_code = TOK_INT_LIT;
        end
        M_FRAC, M_EXP_DIG: begin
          e0      = 1'b1;
          e0_code = TOK_REAL_LIT;
        end
        M_LEADDOT, M_EXP_E, M_EXP_SIGN, M_COLON: begin
          e0      = 1'b1;
          e0_kind = KIND_ERROR;
        end
        M_MINUS: begin
          e0      = 1'b1;
          e0_code = TOK_MINUS;
        end
        M_COMMENT: line_next = line_inc(line);
        default: ;
      endcase
      e1        = 1'b1;
      e1_code   = TOK_EOF;
      mode_next = M_IDLE;
      kw_next   = '1;
      len_next  = '0;
    end else begin
      // Continue the current token; a byte that ends it is rescanned from idle.
      unique case (mode)
        M_IDENT: begin
          if (is_alpha(ch_q) || is_digit(ch_q) || (ch_q == CH_UNDERSCORE)) begin
            kw_next  = kw_after(kw, len, ch_q);
            len_next = len_after(len);
          end else begin
            e0      = 1'b1;
            e0_code = ident_code(kw, len);
            go_idle = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(ch_q)) begin
          end else if (ch_q == CH_DOT) begin
            mode_next = M_FRAC;
          end else if ((ch_q == CH_LOWER_E) || (ch_q == CH_UPPER_E)) begin
            mode_next = M_EXP_E;
          end else begin
            e0      = 1'b1;
            e0_code = TOK_INT_LIT;
            go_idle = 1'b1;
          end
        end
        M_LEADDOT: begin
          if (is_digit(ch_q)) begin
            mode_next = M_INT;
          end else begin
            e0      = 1'b1;
            e0_kind = KIND_ERROR;
            go_idle = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(ch_q)) begin
          end else if ((ch_q == CH_LOWER_E) || (ch_q == CH_UPPER_E)) begin
            mode_next = M_EXP_E;
          end else begin
            e0      = 1'b1;
            e0_code = TOK_REAL_LIT;
            go_idle = 1'b1;
          end
        end
        M_EXP_E: begin
          if ((ch_q == CH_PLUS) || (ch_q == CH_MINUS)) begin
            mode_next = M_EXP_SIGN;
          end else if (is_digit(ch_q)) begin
            mode_next = M_EXP_DIG;
          end else begin
            e0      = 1'b1;
            e0_kind = KIND_ERROR;
            go_idle = 1'b1;
          end
        end
        M_EXP_SIGN: begin
          if (is_digit(ch_q)) begin
            mode_next = M_EXP_DIG;
          end else begin
            e0      = 1'b1;
            e0_kind = KIND_ERROR;
            go_idle = 1'b1;
          end
        end
        M_EXP_DIG: begin
          if (!is_digit(ch_q)) begin
            e0      = 1'b1;
            e0_code = TOK_REAL_LIT;
            go_idle = 1'b1;
          end
        end
        M_COLON: begin
          if (ch_q == CH_EQUAL) begin
            e0        = 1'b1;
            e0_code   = TOK_ASSIGN;
            mode_next = M_IDLE;
          end else begin
            e0      = 1'b1;
            e0_kind = KIND_ERROR;
            go_idle = 1'b1;
          end
        end
        M_MINUS: begin
          if (ch_q == CH_MINUS) begin
            mode_next = M_COMMENT;
          end else begin
            e0      = 1'b1;
            e0_code = TOK_MINUS;
            go_idle = 1'b1;
          end
        end
        M_COMMENT: begin
          if (ch_q == CH_NEWLINE) begin
            line_next = line_inc(line);
            mode_next = M_IDLE;
          end
        end
        default: go_idle = 1'b1;
      endcase

      // Start of a new token from the idle mode.
      if (go_idle) begin
        mode_next = M_IDLE;
        if (is_space(ch_q)) begin
          if (ch_q == CH_NEWLINE) begin
            line_next = line_inc(line);
            e1        = 1'b1;
            e1_kind   = KIND_LINE;
          end
        end else if (is_alpha(ch_q)) begin
          mode_next = M_IDENT;
          kw_next   = kw_after('1, '0, ch_q);
          len_next  = ID_LEN_W'(1);
        end else if (is_digit(ch_q)) begin
          mode_next = M_INT;
        end else if (ch_q == CH_DOT) begin
          mode_next = M_LEADDOT;
        end else if (ch_q == CH_LPAREN) begin
          e1      = 1'b1;
          e1_code = TOK_LPAREN;
        end else if (ch_q == CH_RPAREN) begin
          e1      = 1'b1;
          e1_code = TOK_RPAREN;
        end else if (ch_q == CH_SEMICOLON) begin
          e1      = 1'b1;
          e1_code = TOK_SEMICOLON;
        end else if (ch_q == CH_COMMA) begin
          e1      = 1'b1;
          e1_code = TOK_COMMA;
        end else if (ch_q == CH_PLUS) begin
          e1      = 1'b1;
          e1_code = TOK_PLUS;
        end else if (ch_q == CH_COLON) begin
          mode_next = M_COLON;
        end else if (ch_q == CH_MINUS) begin
          mode_next = M_MINUS;
        end else begin
          e1      = 1'b1;
          e1_kind = KIND_ERROR;
        end
      end
    end
  end

  // Pack the results; the flushed token carries the old line count, the later one the new.
  always_comb begin
    line_ext      = LINE_EXT_W'(line);
    line_next_ext = LINE_EXT_W'(line_next);
    r0.kind       = e0_kind;
    r0.token_code = e0_code;
    r0.line_no    = line_ext[LINE_NO_W-1:0];
    r0.last       = !e1;
    r1.kind       = e1_kind;
    r1.token_code = e1_code;
    r1.line_no    = line_next_ext[LINE_NO_W-1:0];
    r1.last       = 1'b1;
    push.valid    = take && (e0 || e1);
    push.two      = e0 && e1;
    push.first    = e0 ? r0 : r1;
    push.second   = r1;
  end

  // Input register and scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      mode <= M_IDLE;
      kw   <= '1;
      len  <= '0;
      line <= LINE_WIDTH'(1);
    end else begin
      if (chars.valid && chars.ready) begin
        ch_q  <= chars.ch;
        eoi_q <= chars.end_of_input;
      end
      held <= (chars.valid && chars.ready) || (held && !take);
      if (take) begin
        mode <= mode_next;
        kw   <= kw_next;
        len  <= len_next;
        line <= line_next;
      end
    end
  end

endmodule

[hw/rtl/mll_result_queue.sv]
// Result queue: takes one or two results per cycle and delivers one item per cycle while tokens.ready is high.
// Depends on mll_pkg and mll_out_if.
`timescale 1ns / 1ps

module mll_result_queue
  import mll_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  push_t       push,
  output logic        room,
  mll_out_if.source   tokens
);

  result_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                pop;
  logic [QCNT_W-1:0]   push_n;
  result_t             head;

  // Room for a two-result item, from registered state only.
  assign room   = count <= QCNT_W'(QUEUE_DEPTH - 2);
  assign pop    = tokens.valid && tokens.ready;
  assign push_n = push.valid ? (push.two ? QCNT_W'(2) : QCNT_W'(1)) : '0;

  // Head of the queue drives the channel.
  always_comb begin
    head              = entries[rd_ptr];
    tokens.valid      = count != '0;
    tokens.kind       = head.kind;
    tokens.token_code = head.token_code;
    tokens.line_no    = head.line_no;
    tokens.last       = head.last;
  end

  // Storage and pointers.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.first;
      if (push.two) begin
        entries[wr_ptr + QPTR_W'(1)] <= push.second;
      end
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[QPTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + push_n - QCNT_W'(pop);
    end
  end

endmodule

[hw/rtl/micro_language_lexer.sv]
// Top level of the micro language lexer: core and result queue.
// Depends on mll_pkg, mll_in_if, mll_out_if, mll_core and mll_result_queue.
//
// Usage:
//   chars  carries one source byte per item (ch), or an end-of-input mark
//          (end_of_input = 1, ch ignored).
//   tokens carries result items: kind (token, line end, lexical error),
//          token_code, line_no and last, which flags the final result
//          caused by an input item. An item causes zero, one or two results.
//   Each accepted item is scanned while it sits in the input register, and
//   its results are written to the result queue, whose head drives tokens.
//   One item is taken every cycle as long as the four-entry result queue
//   holds at most two results; the combinational scan logic sets this rate.
//   A sustained run of two-result items is limited by the output, which
//   delivers results one at a time.
//   When the receiver stalls, the queue fills and chars.ready drops once the
//   queue cannot take two more results; nothing is lost.
//   Synchronous reset empties the queue and input register, returns the
//   scanner to idle and sets the line count to one.
`timescale 1ns / 1ps

module micro_language_lexer
  import mll_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mll_in_if.sink    chars,
  mll_out_if.source tokens
);

  push_t push;
  logic  room;

  mll_core u_core (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .room  (room),
    .push  (push)
  );

  mll_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tokens (tokens)
  );

endmodule

[hw/rtl/mll_checker.sv]
// Port-level assertions for the micro language lexer, bound to the top level.
// Depends on mll_pkg and micro_language_lexer.
`timescale 1ns / 1ps

module mll_checker
  import mll_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [3:0]  out_token_code,
  input logic [15:0] out_line_no,
  input logic        out_last
);

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  // A stalled result holds still.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_token_code)
      && $stable(out_line_no) && $stable(out_last))
    else $error("stalled result changed");

  // Line-end and error results carry no token code.
  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind != KIND_TOKEN) |-> out_token_code == TOK_NONE)
    else $error("non-token result with a token code");

  // A line end is always the final result of its item.
  a_line_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_LINE) |-> out_last)
    else $error("line end not flagged last");

  // Line numbers start at one and never wrap to zero.
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_line_no != 16'd0)
    else $error("line number zero");

endmodule

bind micro_language_lexer mll_checker u_mll_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (tokens.valid),
  .out_ready      (tokens.ready),
  .out_kind       (tokens.kind),
  .out_token_code (tokens.token_code),
  .out_line_no    (tokens.line_no),
  .out_last       (tokens.last)
);
